FILE: rtl/timer_divider_search_unit_macros.svh
// Assertion helpers for timer_divider_search_unit.sv.
`ifndef TIMER_DIVIDER_SEARCH_UNIT_MACROS_SVH
`define TIMER_DIVIDER_SEARCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop in the same cycle as cond.
`define TDS_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("timer divider search check failed");

// Check prop in the cycle after cond.
`define TDS_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("timer divider search check failed");

`else

`define TDS_ASSERT_SAME(label, cond, prop)
`define TDS_ASSERT_NEXT(label, cond, prop)

`endif

`endif

FILE: rtl/tds_pkg.sv
package tds_pkg;

   // Default search limits.
   localparam logic [31:0] TDS_MODULO_MAX     = 32'd65535;
   localparam int          TDS_PRESCALE_STEPS = 8;

   // Exponent width covers the largest supported prescale step count.
   localparam int TDS_EXP_W  = 4;
   localparam int TDS_QUOT_W = 32;
   localparam int TDS_DIV_W  = 30;

   // ceil(2^34 / 5): n / 5 == (n * magic) >> 34 for any 32-bit n.
   localparam logic [31:0] TDS_DIV5_MAGIC = 32'hCCCCCCCD;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_SMALL = 2'd1,
      STATUS_TOO_LARGE = 2'd2
   } status_type;

   // Best fit found for one multiplier.
   typedef struct packed {
      logic                  ok;
      logic [TDS_EXP_W-1:0]  exp;
      logic [TDS_QUOT_W-1:0] modulo;
   } cand_type;

endpackage

FILE: rtl/tds_mult_search.sv
module tds_mult_search import tds_pkg::*; #(
   parameter logic [31:0] MODULO_MAX     = TDS_MODULO_MAX,
   parameter int          PRESCALE_STEPS = TDS_PRESCALE_STEPS
) (
   input  logic [PRESCALE_STEPS-1:0][TDS_QUOT_W-1:0] quot,
   output cand_type                                  cand
);

   logic                  found;
   logic                  hit_small;
   logic [TDS_EXP_W-1:0]  hit_exp;
   logic [TDS_QUOT_W-1:0] hit_mod;

   // Take the lowest exponent that either fits or collapses to zero.
   always_comb begin
      found     = 1'b0;
      hit_small = 1'b0;
      hit_exp   = '0;
      hit_mod   = '0;
      for (int e = PRESCALE_STEPS - 1; e >= 0; e--) begin
         if ((quot[e] <= TDS_QUOT_W'(1)) || ((quot[e] - TDS_QUOT_W'(1)) <= MODULO_MAX)) begin
            found     = 1'b1;
            hit_small = (quot[e] <= TDS_QUOT_W'(1));
            hit_exp   = TDS_EXP_W'(e);
            hit_mod   = quot[e] - TDS_QUOT_W'(1);
         end
      end
      cand.ok     = found && !hit_small;
      cand.exp    = cand.ok ? hit_exp : '0;
      cand.modulo = cand.ok ? hit_mod : '0;
   end

endmodule

FILE: rtl/timer_divider_search_unit.sv
// Throughput: one request per cycle unless rsp_stall backs up the pipeline; four
//    registered stages (input, quotient lanes, per-multiplier fit, result) hand
//    items along, with one constant reciprocal multiply per divide-by-ten lane.
// Reset: synchronous, active high; clears all stage valid flags, payload is not reset.
`include "timer_divider_search_unit_macros.svh"

module timer_divider_search_unit import tds_pkg::*; #(
   parameter logic [31:0] MODULO_MAX     = TDS_MODULO_MAX,
   parameter int          PRESCALE_STEPS = TDS_PRESCALE_STEPS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_period_ticks,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_mult_select,
   output logic [2:0]  rsp_prescale_select,
   output logic [15:0] rsp_modulo
);

   // Divide-by-ten lanes: multiplier 10 uses shift e, 20 uses e+1, 40 uses e+2.
   localparam int NK = PRESCALE_STEPS + 2;

   // ------------------------------------------------------------------
   // Pipeline control: a stage takes new data when empty or draining.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic s1_ready, s2_ready, s3_ready, out_ready;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign req_stall = !s1_ready;
   assign rsp_valid = rsp_valid_ff;

   assign s1_valid_in  = s1_ready  ? req_valid    : s1_valid_ff;
   assign s2_valid_in  = s2_ready  ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in  = s3_ready  ? s2_valid_ff  : s3_valid_ff;
   assign rsp_valid_in = out_ready ? s3_valid_ff  : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: capture the requested tick count.
   // ------------------------------------------------------------------
   logic [31:0] t_ff;

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         t_ff <= req_period_ticks;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: rounded quotients for every multiplier and exponent.
   // For d = 10 * 2^k: round(t / d) = ((t >> k) + 5) / 10 = (((t >> k) + 5) >> 1) / 5.
   // For d = 2^e: round(t / d) = (t + 2^(e-1)) >> e.
   // ------------------------------------------------------------------
   logic [NK-1:0][TDS_DIV_W-1:0]              u_in, u_ff;
   logic [PRESCALE_STEPS-1:0][TDS_QUOT_W-1:0] q1_in, q1_ff;

   for (genvar k = 0; k < NK; k++) begin : g_div10
      logic [32:0] biased;
      logic [31:0] halved;
      logic [63:0] prod;
      assign biased  = {1'b0, t_ff >> k} + 33'd5;
      assign halved  = biased[32:1];
      assign prod    = {32'd0, halved} * {32'd0, TDS_DIV5_MAGIC};
      assign u_in[k] = prod[63:34];
   end

   for (genvar e = 0; e < PRESCALE_STEPS; e++) begin : g_div2
      if (e == 0) begin : g_exact
         assign q1_in[e] = t_ff;
      end else begin : g_round
         logic [32:0] biased;
         logic [32:0] shifted;
         assign biased   = {1'b0, t_ff} + (33'd1 << (e - 1));
         assign shifted  = biased >> e;
         assign q1_in[e] = shifted[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         u_ff  <= u_in;
         q1_ff <= q1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: first fitting exponent for each multiplier.
   // ------------------------------------------------------------------
   logic [3:0][PRESCALE_STEPS-1:0][TDS_QUOT_W-1:0] quot;
   cand_type [3:0]                                 cand_in, cand_ff;
   logic                                           small_in, small_ff;

   for (genvar e = 0; e < PRESCALE_STEPS; e++) begin : g_quot
      assign quot[0][e] = q1_ff[e];
      assign quot[1][e] = TDS_QUOT_W'(u_ff[e]);
      assign quot[2][e] = TDS_QUOT_W'(u_ff[e + 1]);
      assign quot[3][e] = TDS_QUOT_W'(u_ff[e + 2]);
   end

   for (genvar m = 0; m < 4; m++) begin : g_search
      tds_mult_search #(
         .MODULO_MAX     (MODULO_MAX),
         .PRESCALE_STEPS (PRESCALE_STEPS)
      ) u_search (
         .quot (quot[m]),
         .cand (cand_in[m])
      );
   end

   // The multiplier one, prescaler one try collapses to zero: period too small.
   assign small_in = (q1_ff[0] <= TDS_QUOT_W'(1));

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         cand_ff  <= cand_in;
         small_ff <= small_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: keep the largest modulo, the lower multiplier on a tie.
   // Rejected candidates carry a zero modulo, so they never win.
   // ------------------------------------------------------------------
   logic       [1:0] win01_idx, win23_idx, best_idx;
   cand_type         win01, win23, best;

   status_type            rsp_status_ff, rsp_status_in;
   logic [1:0]            rsp_mult_ff, rsp_mult_in;
   logic [TDS_EXP_W-1:0]  rsp_exp_ff, rsp_exp_in;
   logic [TDS_QUOT_W-1:0] rsp_mod_ff, rsp_mod_in;

   always_comb begin
      if (cand_ff[1].modulo > cand_ff[0].modulo) begin
         win01_idx = 2'd1;
         win01     = cand_ff[1];
      end else begin
         win01_idx = 2'd0;
         win01     = cand_ff[0];
      end
      if (cand_ff[3].modulo > cand_ff[2].modulo) begin
         win23_idx = 2'd3;
         win23     = cand_ff[3];
      end else begin
         win23_idx = 2'd2;
         win23     = cand_ff[2];
      end
      if (win23.modulo > win01.modulo) begin
         best_idx = win23_idx;
         best     = win23;
      end else begin
         best_idx = win01_idx;
         best     = win01;
      end

      // Drop the selection fields unless the search succeeded.
      rsp_status_in = STATUS_OK;
      rsp_mult_in   = '0;
      rsp_exp_in    = '0;
      rsp_mod_in    = '0;
      if (small_ff) begin
         rsp_status_in = STATUS_TOO_SMALL;
      end else if (best.modulo == '0) begin
         rsp_status_in = STATUS_TOO_LARGE;
      end else begin
         rsp_mult_in = best_idx;
         rsp_exp_in  = best.exp;
         rsp_mod_in  = best.modulo;
      end
   end

   // Hold the result while the consumer stalls.
   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_status_ff <= rsp_status_in;
         rsp_mult_ff   <= rsp_mult_in;
         rsp_exp_ff    <= rsp_exp_in;
         rsp_mod_ff    <= rsp_mod_in;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_mult_select     = rsp_mult_ff;
   assign rsp_prescale_select = 3'(rsp_exp_ff);
   assign rsp_modulo          = rsp_mod_ff[15:0];

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `TDS_ASSERT_SAME(a_ok_mod_range, rsp_valid_ff && (rsp_status_ff == STATUS_OK), (rsp_mod_ff != '0) && (rsp_mod_ff <= MODULO_MAX))
   `TDS_ASSERT_SAME(a_fail_zero, rsp_valid_ff && (rsp_status_ff != STATUS_OK), (rsp_mod_ff == '0) && (rsp_mult_ff == '0) && (rsp_exp_ff == '0))
   `TDS_ASSERT_SAME(a_exp_range, rsp_valid_ff, int'(rsp_exp_ff) < PRESCALE_STEPS)
   `TDS_ASSERT_SAME(a_full_stall, s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff && rsp_stall, req_stall)
   `TDS_ASSERT_NEXT(a_hold_stage3, s3_valid_ff && rsp_valid_ff && rsp_stall, s3_valid_ff)

endmodule

FILE: test/tds_checker.sv
module tds_checker import tds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_period_ticks,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [1:0]  rsp_mult_select,
   input  logic [2:0]  rsp_prescale_select,
   input  logic [15:0] rsp_modulo,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);

   localparam int unsigned MULT_FACTOR [4] = '{1, 10, 20, 40};

   typedef struct packed {
      status_type  status;
      logic [1:0]  mult;
      logic [2:0]  exp;
      logic [15:0] modulo;
   } divider_fit_type;

   divider_fit_type expected_fits [$];

   // Rounded-half-up quotient per try; the widest modulo that fits wins.
   function automatic divider_fit_type predict_divider(input logic [31:0] ticks);
      divider_fit_type fit;
      logic [63:0]     div;
      logic [63:0]     quot;
      logic [63:0]     best_mod;
      logic [1:0]      best_mult;
      logic [2:0]      best_exp;
      best_mod  = '0;
      best_mult = '0;
      best_exp  = '0;
      fit       = '0;
      for (int m = 0; m < 4; m++) begin
         for (int e = 0; e < TDS_PRESCALE_STEPS; e++) begin
            div  = 64'(MULT_FACTOR[m]) << e;
            quot = (64'(ticks) + (div >> 1)) / div;
            if (quot <= 64'd1) begin
               if (m == 0 && e == 0) begin
                  fit.status = STATUS_TOO_SMALL;
                  return fit;
               end
               break;
            end
            if (quot - 64'd1 <= 64'(TDS_MODULO_MAX)) begin
               if (quot - 64'd1 > best_mod) begin
                  best_mod  = quot - 64'd1;
                  best_mult = 2'(m);
                  best_exp  = 3'(e);
               end
               break;
            end
         end
      end
      if (best_mod == '0) begin
         fit.status = STATUS_TOO_LARGE;
      end else begin
         fit.status = STATUS_OK;
         fit.mult   = best_mult;
         fit.exp    = best_exp;
         fit.modulo = best_mod[15:0];
      end
      return fit;
   endfunction

   always @(posedge clock) begin
      divider_fit_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         fail_count    <= 0;
         pending_count <= 0;
         checked_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_fits.size() == 0) begin
               $error("response with no request outstanding");
               errs++;
            end else begin
               want = expected_fits.pop_front();
               checked_count <= checked_count + 1;
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_mult_select !== want.mult) begin
                  $error("mult_select expected %0d got %0d", want.mult, rsp_mult_select);
                  errs++;
               end
               if (rsp_prescale_select !== want.exp) begin
                  $error("prescale_select expected %0d got %0d", want.exp,
                         rsp_prescale_select);
                  errs++;
               end
               if (rsp_modulo !== want.modulo) begin
                  $error("modulo expected %0d got %0d", want.modulo, rsp_modulo);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_fits.push_back(predict_divider(req_period_ticks));
         pending_count <= expected_fits.size();
         fail_count    <= fail_count + errs;
      end
   end

endmodule

FILE: test/tb_timer_divider_search_unit.sv
module tb_timer_divider_search_unit;

   // Long enough for the slowest mix of sender gaps and receiver stalls.
   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 12;
   localparam int NUM_CORNERS    = 23;

   localparam int unsigned MULT_FACTORS [4] = '{1, 10, 20, 40};

   // Hand-picked periods: too small, rounding edges, multiplier skips, ties,
   // the last period that still fits and the first one that does not.
   localparam logic [31:0] CORNER_PERIODS [NUM_CORNERS] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd14, 32'd15, 32'd16,
      32'd65535, 32'd65536, 32'd65537, 32'd131071, 32'd131072, 32'd131073,
      32'd655360, 32'd655365, 32'd1310720, 32'd335544320, 32'd335546879,
      32'd335546880, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_period_ticks = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_mult_select;
   logic [2:0]  rsp_prescale_select;
   logic [15:0] rsp_modulo;

   int fail_count;
   int pending_count;
   int checked_count;
   int cycle_count   = 0;
   int stall_pct     = 0;
   int holdoff_count = 0;
   int sent_count    = 0;

   timer_divider_search_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_period_ticks    (req_period_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_mult_select     (rsp_mult_select),
      .rsp_prescale_select (rsp_prescale_select),
      .rsp_modulo          (rsp_modulo)
   );

   tds_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_period_ticks    (req_period_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_mult_select     (rsp_mult_select),
      .rsp_prescale_select (rsp_prescale_select),
      .rsp_modulo          (rsp_modulo),
      .fail_count          (fail_count),
      .pending_count       (pending_count),
      .checked_count       (checked_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_timer_divider_search_unit: errors");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold-off whenever the stimulus
   // process bumps holdoff_count. Count the hold-off here, not in the sender.
   initial begin : drain_side
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (holdoff_count != served) begin
            served = holdoff_count;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Pick a period: full range, log-spread, or hugging a fit boundary of a
   // random multiplier and prescaler (either end of the modulo range).
   function automatic logic [31:0] pick_period();
      logic [63:0] div;
      logic [63:0] base;
      div = 64'(MULT_FACTORS[$urandom_range(0, 3)]);
      div = div << $urandom_range(0, 7);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            return $urandom;
         end
         3, 4, 5: begin
            return $urandom >> $urandom_range(0, 31);
         end
         6, 7, 8: begin
            base = 64'd65536 * div;
            return 32'(base - div + 64'($urandom_range(0, 2 * 32'(div) + 2)));
         end
         default: begin
            return 32'($urandom_range(0, 3 * 32'(div)));
         end
      endcase
   endfunction

   // Offer one request after a random gap; hold it until accepted.
   task automatic send_request(input logic [31:0] period, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_period_ticks <= period;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic run_random(input int count, input int idle_pct, input int stall);
      stall_pct <= stall;
      repeat (count) send_request(pick_period(), idle_pct);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners, back to back with no stalls.
      foreach (CORNER_PERIODS[i]) send_request(CORNER_PERIODS[i], 0);

      // Random phases: free running, sender gaps, receiver stalls, both.
      run_random(350, 0, 0);
      run_random(350, 73, 0);
      run_random(350, 0, 73);
      run_random(350, 29, 29);

      // Hold the output for a long stretch while requests keep coming, so
      // the pipeline fills and pushes back on the request side.
      stall_pct     <= 0;
      holdoff_count <= holdoff_count + 1;
      repeat (100) send_request(pick_period(), 0);
      run_random(250, 29, 29);

      req_valid <= 1'b0;
      stall_pct <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked: directed corners, four",
               sent_count, checked_count);
      $display("idle/stall mixes and a long output hold-off with input backpressure");
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_timer_divider_search_unit: clean");
      end else begin
         $display("tb_timer_divider_search_unit: errors");
      end
      $finish;
   end

endmodule
